// ===== rtl/ishph_pkg.sv =====
// ----------------------------------------------------------------------------
// ishph_pkg: shared types, constants and functions
// Control bundles, status codes, SHA-512 tables and alphabet helpers for the
// iterated SHA-512 password hash block.
// ----------------------------------------------------------------------------
package ishph_pkg;

    localparam int SET_LEN    = 12;
    localparam int SFILL_W    = 4;
    localparam int MAX_PWD    = 128;
    localparam int PWD_AW     = 7;
    localparam int PFILL_W    = 8;
    localparam int MIN_EXP    = 7;
    localparam int MAX_EXP    = 30;
    localparam int HASH_CHARS = 55;
    localparam int ITER_W     = 31;

    // opcodes
    localparam logic [1:0] OP_SETTING  = 2'd0;
    localparam logic [1:0] OP_PASSWORD = 2'd1;
    localparam logic [1:0] OP_FINISH   = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_PFX   = 3'd1;
    localparam logic [2:0] ST_BAD_EXP   = 3'd2;
    localparam logic [2:0] ST_SHORT_SET = 3'd3;
    localparam logic [2:0] ST_PWD_LONG  = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic       set_wr;
        logic       pwd_wr;
        logic       clear_fills;
        logic       msg_init;
        logic       blk_init;
        logic       load;
        logic       first;
        logic [7:0] gpos;
        logic       round;
        logic [6:0] t;
        logic       add;
        logic       copy_hb;
        logic [5:0] emit_pos;
        logic       emit_err;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] chk;
        logic [4:0] expo;
        logic       two_blocks;
    } stat_t;

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] init_h(input logic [2:0] j);
        case (j)
            3'd0: init_h = 64'h6a09e667f3bcc908;
            3'd1: init_h = 64'hbb67ae8584caa73b;
            3'd2: init_h = 64'h3c6ef372fe94f82b;
            3'd3: init_h = 64'ha54ff53a5f1d36f1;
            3'd4: init_h = 64'h510e527fade682d1;
            3'd5: init_h = 64'h9b05688c2b3e6c1f;
            3'd6: init_h = 64'h1f83d9abfb41bd6b;
            default: init_h = 64'h5be0cd19137e2179;
        endcase
    endfunction

    function automatic logic [63:0] round_k(input logic [6:0] t);
        case (t)
            7'd0:  round_k = 64'h428a2f98d728ae22;
            7'd1:  round_k = 64'h7137449123ef65cd;
            7'd2:  round_k = 64'hb5c0fbcfec4d3b2f;
            7'd3:  round_k = 64'he9b5dba58189dbbc;
            7'd4:  round_k = 64'h3956c25bf348b538;
            7'd5:  round_k = 64'h59f111f1b605d019;
            7'd6:  round_k = 64'h923f82a4af194f9b;
            7'd7:  round_k = 64'hab1c5ed5da6d8118;
            7'd8:  round_k = 64'hd807aa98a3030242;
            7'd9:  round_k = 64'h12835b0145706fbe;
            7'd10: round_k = 64'h243185be4ee4b28c;
            7'd11: round_k = 64'h550c7dc3d5ffb4e2;
            7'd12: round_k = 64'h72be5d74f27b896f;
            7'd13: round_k = 64'h80deb1fe3b1696b1;
            7'd14: round_k = 64'h9bdc06a725c71235;
            7'd15: round_k = 64'hc19bf174cf692694;
            7'd16: round_k = 64'he49b69c19ef14ad2;
            7'd17: round_k = 64'hefbe4786384f25e3;
            7'd18: round_k = 64'h0fc19dc68b8cd5b5;
            7'd19: round_k = 64'h240ca1cc77ac9c65;
            7'd20: round_k = 64'h2de92c6f592b0275;
            7'd21: round_k = 64'h4a7484aa6ea6e483;
            7'd22: round_k = 64'h5cb0a9dcbd41fbd4;
            7'd23: round_k = 64'h76f988da831153b5;
            7'd24: round_k = 64'h983e5152ee66dfab;
            7'd25: round_k = 64'ha831c66d2db43210;
            7'd26: round_k = 64'hb00327c898fb213f;
            7'd27: round_k = 64'hbf597fc7beef0ee4;
            7'd28: round_k = 64'hc6e00bf33da88fc2;
            7'd29: round_k = 64'hd5a79147930aa725;
            7'd30: round_k = 64'h06ca6351e003826f;
            7'd31: round_k = 64'h142929670a0e6e70;
            7'd32: round_k = 64'h27b70a8546d22ffc;
            7'd33: round_k = 64'h2e1b21385c26c926;
            7'd34: round_k = 64'h4d2c6dfc5ac42aed;
            7'd35: round_k = 64'h53380d139d95b3df;
            7'd36: round_k = 64'h650a73548baf63de;
            7'd37: round_k = 64'h766a0abb3c77b2a8;
            7'd38: round_k = 64'h81c2c92e47edaee6;
            7'd39: round_k = 64'h92722c851482353b;
            7'd40: round_k = 64'ha2bfe8a14cf10364;
            7'd41: round_k = 64'ha81a664bbc423001;
            7'd42: round_k = 64'hc24b8b70d0f89791;
            7'd43: round_k = 64'hc76c51a30654be30;
            7'd44: round_k = 64'hd192e819d6ef5218;
            7'd45: round_k = 64'hd69906245565a910;
            7'd46: round_k = 64'hf40e35855771202a;
            7'd47: round_k = 64'h106aa07032bbd1b8;
            7'd48: round_k = 64'h19a4c116b8d2d0c8;
            7'd49: round_k = 64'h1e376c085141ab53;
            7'd50: round_k = 64'h2748774cdf8eeb99;
            7'd51: round_k = 64'h34b0bcb5e19b48a8;
            7'd52: round_k = 64'h391c0cb3c5c95a63;
            7'd53: round_k = 64'h4ed8aa4ae3418acb;
            7'd54: round_k = 64'h5b9cca4f7763e373;
            7'd55: round_k = 64'h682e6ff3d6b2b8a3;
            7'd56: round_k = 64'h748f82ee5defb2fc;
            7'd57: round_k = 64'h78a5636f43172f60;
            7'd58: round_k = 64'h84c87814a1f0ab72;
            7'd59: round_k = 64'h8cc702081a6439ec;
            7'd60: round_k = 64'h90befffa23631e28;
            7'd61: round_k = 64'ha4506cebde82bde9;
            7'd62: round_k = 64'hbef9a3f7b2c67915;
            7'd63: round_k = 64'hc67178f2e372532b;
            7'd64: round_k = 64'hca273eceea26619c;
            7'd65: round_k = 64'hd186b8c721c0c207;
            7'd66: round_k = 64'heada7dd6cde0eb1e;
            7'd67: round_k = 64'hf57d4f7fee6ed178;
            7'd68: round_k = 64'h06f067aa72176fba;
            7'd69: round_k = 64'h0a637dc5a2c898a6;
            7'd70: round_k = 64'h113f9804bef90dae;
            7'd71: round_k = 64'h1b710b35131c471b;
            7'd72: round_k = 64'h28db77f523047d84;
            7'd73: round_k = 64'h32caab7b40c72493;
            7'd74: round_k = 64'h3c9ebe0a15c9bebc;
            7'd75: round_k = 64'h431d67c49c100d4c;
            7'd76: round_k = 64'h4cc5d4becb3e42b6;
            7'd77: round_k = 64'h597f299cfc657e2a;
            7'd78: round_k = 64'h5fcb6fab3ad6faec;
            7'd79: round_k = 64'h6c44198c4a475817;
            default: round_k = 64'h0;
        endcase
    endfunction

    // symbol index to character of "./0-9A-Za-z"
    function automatic logic [7:0] alpha_char(input logic [5:0] idx);
        logic [7:0] x;
        x = {2'b00, idx};
        if (idx < 6'd2)
            alpha_char = (idx == 6'd0) ? 8'h2e : 8'h2f;
        else if (idx < 6'd12)
            alpha_char = x + 8'd46;
        else if (idx < 6'd38)
            alpha_char = x + 8'd53;
        else
            alpha_char = x + 8'd59;
    endfunction

    // character to symbol index; 64 when not in the alphabet
    function automatic logic [6:0] alpha_index(input logic [7:0] c);
        logic [7:0] x;
        x = 8'h40;
        if (c == 8'h2e)
            x = 8'd0;
        else if (c == 8'h2f)
            x = 8'd1;
        else if (c >= 8'h30 && c <= 8'h39)
            x = c - 8'd46;
        else if (c >= 8'h41 && c <= 8'h5a)
            x = c - 8'd53;
        else if (c >= 8'h61 && c <= 8'h7a)
            x = c - 8'd59;
        alpha_index = x[6:0];
    endfunction

endpackage

// ===== rtl/ishph_dp.sv =====
// ----------------------------------------------------------------------------
// ishph_dp: hash datapath
// Setting and password stores, SHA-512 message loader, one-round-per-cycle
// compression unit, digest registers and the output character encoder.
// ----------------------------------------------------------------------------
module ishph_dp
(
    input  logic            clk,
    input  logic            rst_n,
    input  ishph_pkg::cmd_t cmd,
    input  logic [7:0]      data_byte,
    output ishph_pkg::stat_t stat,
    output logic [7:0]      out_char
);

    logic [7:0]                     set_reg [0:ishph_pkg::SET_LEN-1];
    logic [ishph_pkg::SFILL_W-1:0]  sfill_reg;
    logic [7:0]                     pwd_mem [0:ishph_pkg::MAX_PWD-1];
    logic [ishph_pkg::PFILL_W-1:0]  pfill_reg;
    logic                           ovf_reg;
    logic [7:0]                     pwd_rd_reg;
    logic [7:0]                     gpos_q_reg;
    logic                           load_q_reg;
    logic [1023:0]                  w_reg;
    logic [63:0]                    v_reg [0:7];
    logic [63:0]                    h_reg [0:7];
    logic [63:0]                    hb_reg [0:7];

    logic [8:0]  msg_len;
    logic [8:0]  pre_len;
    logic [11:0] len_bits;
    logic [7:0]  last_pos;
    logic [7:0]  pwd_addr_full;
    logic [7:0]  in_byte;
    logic [7:0]  pre_byte;
    logic [63:0] w_cur;
    logic [63:0] w_new;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [6:0]  ex_idx;
    logic [2:0]  chk;

    // big-endian byte of the previous message digest
    function automatic logic [7:0] hb_byte(input logic [63:0] w, input logic [2:0] b);
        logic [63:0] s;
        s = w >> {~b, 3'b000};
        hb_byte = s[7:0];
    endfunction

    // setting and password load, fill counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sfill_reg <= '0;
            pfill_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.clear_fills)
        begin
            sfill_reg <= '0;
            pfill_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.set_wr && sfill_reg < ishph_pkg::SFILL_W'(ishph_pkg::SET_LEN))
                sfill_reg <= sfill_reg + 1'b1;
            if (cmd.pwd_wr)
            begin
                if (pfill_reg < ishph_pkg::PFILL_W'(ishph_pkg::MAX_PWD))
                    pfill_reg <= pfill_reg + 1'b1;
                else
                    ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_wr && sfill_reg < ishph_pkg::SFILL_W'(ishph_pkg::SET_LEN))
            set_reg[sfill_reg] <= data_byte;
    end

    // password memory: one write port, one registered read port
    assign pwd_addr_full = cmd.gpos - pre_len[7:0];

    always_ff @(posedge clk)
    begin
        if (cmd.pwd_wr && pfill_reg < ishph_pkg::PFILL_W'(ishph_pkg::MAX_PWD))
            pwd_mem[pfill_reg[ishph_pkg::PWD_AW-1:0]] <= data_byte;
        pwd_rd_reg <= pwd_mem[pwd_addr_full[ishph_pkg::PWD_AW-1:0]];
    end

    // setting check
    always_comb
    begin
        ex_idx = ishph_pkg::alpha_index(set_reg[3]);
        if (sfill_reg < 4'd1 || set_reg[0] != 8'h24)
            chk = ishph_pkg::ST_BAD_PFX;
        else if (sfill_reg < 4'd2 || set_reg[1] != 8'h53)
            chk = ishph_pkg::ST_BAD_PFX;
        else if (sfill_reg < 4'd3 || set_reg[2] != 8'h24)
            chk = ishph_pkg::ST_BAD_PFX;
        else if (sfill_reg < 4'd4)
            chk = ishph_pkg::ST_BAD_EXP;
        else if (ex_idx < 7'(ishph_pkg::MIN_EXP) || ex_idx > 7'(ishph_pkg::MAX_EXP))
            chk = ishph_pkg::ST_BAD_EXP;
        else if (sfill_reg < ishph_pkg::SFILL_W'(ishph_pkg::SET_LEN))
            chk = ishph_pkg::ST_SHORT_SET;
        else if (ovf_reg)
            chk = ishph_pkg::ST_PWD_LONG;
        else
            chk = ishph_pkg::ST_OK;
    end

    // message geometry
    assign pre_len  = cmd.first ? 9'd8 : 9'd64;
    assign msg_len  = pre_len + {1'b0, pfill_reg};
    assign len_bits = {msg_len, 3'b000};
    assign last_pos = stat.two_blocks ? 8'd255 : 8'd127;

    assign stat.chk        = chk;
    assign stat.expo       = ex_idx[4:0];
    assign stat.two_blocks = (msg_len > 9'd111);

    // padded message byte for the delayed position
    always_comb
    begin
        if (cmd.first)
            pre_byte = set_reg[4'd4 + {1'b0, gpos_q_reg[2:0]}];
        else
            pre_byte = hb_byte(hb_reg[gpos_q_reg[5:3]], gpos_q_reg[2:0]);
        if ({1'b0, gpos_q_reg} < msg_len)
            in_byte = ({1'b0, gpos_q_reg} < pre_len) ? pre_byte : pwd_rd_reg;
        else if ({1'b0, gpos_q_reg} == msg_len)
            in_byte = 8'h80;
        else if (gpos_q_reg == last_pos)
            in_byte = len_bits[7:0];
        else if (gpos_q_reg == last_pos - 8'd1)
            in_byte = {4'b0000, len_bits[11:8]};
        else
            in_byte = 8'h00;
    end

    // round logic
    always_comb
    begin
        w_cur = w_reg[1023:960];
        w_new = (ishph_pkg::rotr(w_reg[127:64], 19) ^ ishph_pkg::rotr(w_reg[127:64], 61)
                 ^ (w_reg[127:64] >> 6))
              + w_reg[447:384]
              + (ishph_pkg::rotr(w_reg[959:896], 1) ^ ishph_pkg::rotr(w_reg[959:896], 8)
                 ^ (w_reg[959:896] >> 7))
              + w_cur;
        t1 = v_reg[7]
           + (ishph_pkg::rotr(v_reg[4], 14) ^ ishph_pkg::rotr(v_reg[4], 18)
              ^ ishph_pkg::rotr(v_reg[4], 41))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + ishph_pkg::round_k(cmd.t) + w_cur;
        t2 = (ishph_pkg::rotr(v_reg[0], 28) ^ ishph_pkg::rotr(v_reg[0], 34)
              ^ ishph_pkg::rotr(v_reg[0], 39))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // load pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_q_reg <= 1'b0;
        else
            load_q_reg <= cmd.load;
    end

    // schedule window, working variables, digest
    always_ff @(posedge clk)
    begin
        gpos_q_reg <= cmd.gpos;
        if (load_q_reg)
            w_reg <= {w_reg[1015:0], in_byte};
        else if (cmd.round)
            w_reg <= {w_reg[959:0], w_new};
        for (int j = 0; j < 8; j++)
        begin
            if (cmd.msg_init)
                h_reg[j] <= ishph_pkg::init_h(3'(j));
            else if (cmd.add)
                h_reg[j] <= h_reg[j] + v_reg[j];
            if (cmd.blk_init)
                v_reg[j] <= h_reg[j];
            if (cmd.copy_hb)
                hb_reg[j] <= h_reg[j];
        end
        if (cmd.round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // output character: setting bytes, then base64 of the final digest
    always_comb
    begin
        logic [5:0]  ep;
        logic [6:0]  b;
        logic [6:0]  bj;
        logic [23:0] v;
        logic [23:0] s;
        ep = cmd.emit_pos - 6'd12;
        b  = {2'b00, ep[5:2], 1'b0} + {3'b000, ep[5:2]};
        v  = '0;
        for (int j = 0; j < 3; j++)
        begin
            bj = b + 7'(j);
            if (bj < 7'd64)
                v[8*j +: 8] = hb_byte(hb_reg[bj[5:3]], bj[2:0]);
        end
        // shift by 6 * k, k = position within the group of four
        s = v >> ({1'b0, ep[1:0], 2'b00} + {2'b00, ep[1:0], 1'b0});
        if (cmd.emit_err)
            out_char = 8'h00;
        else if (cmd.emit_pos < 6'(ishph_pkg::SET_LEN))
            out_char = set_reg[cmd.emit_pos[3:0]];
        else
            out_char = ishph_pkg::alpha_char(s[5:0]);
    end

endmodule

// ===== rtl/ishph_ctrl.sv =====
// ----------------------------------------------------------------------------
// ishph_ctrl: hash sequencer
// Handles the input handshake, walks messages, blocks, load cycles and rounds
// of the iterated hash, and sequences the result characters.
// ----------------------------------------------------------------------------
module ishph_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       opcode,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       status,
    output logic             last,
    input  ishph_pkg::stat_t stat,
    output ishph_pkg::cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b00000000001,
        S_CHECK     = 11'b00000000010,
        S_MSG_START = 11'b00000000100,
        S_BLK_START = 11'b00000001000,
        S_LOAD      = 11'b00000010000,
        S_FLUSH     = 11'b00000100000,
        S_ROUND     = 11'b00001000000,
        S_ADD       = 11'b00010000000,
        S_MSG_DONE  = 11'b00100000000,
        S_EMIT      = 11'b01000000000,
        S_ERR       = 11'b10000000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [6:0]                   pos_reg, pos_next;
    logic                         blk_reg, blk_next;
    logic [6:0]                   t_reg, t_next;
    logic [ishph_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic                         first_reg, first_next;
    logic [5:0]                   epos_reg, epos_next;
    logic [2:0]                   stat_reg, stat_next;
    logic                         in_acc;
    logic                         out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            blk_reg   <= 1'b0;
            t_reg     <= '0;
            iter_reg  <= '0;
            first_reg <= 1'b0;
            epos_reg  <= '0;
            stat_reg  <= ishph_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            blk_reg   <= blk_next;
            t_reg     <= t_next;
            iter_reg  <= iter_next;
            first_reg <= first_next;
            epos_reg  <= epos_next;
            stat_reg  <= stat_next;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        blk_next   = blk_reg;
        t_next     = t_reg;
        iter_next  = iter_reg;
        first_next = first_reg;
        epos_next  = epos_reg;
        stat_next  = stat_reg;
        cmd        = '0;
        cmd.first    = first_reg;
        cmd.gpos     = {blk_reg, pos_reg};
        cmd.t        = t_reg;
        cmd.emit_pos = epos_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        last       = 1'b0;
        status     = ishph_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_acc)
                begin
                    if (opcode == ishph_pkg::OP_SETTING)
                        cmd.set_wr = 1'b1;
                    else if (opcode == ishph_pkg::OP_PASSWORD)
                        cmd.pwd_wr = 1'b1;
                    else if (opcode == ishph_pkg::OP_FINISH)
                        state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                stat_next = stat.chk;
                if (stat.chk != ishph_pkg::ST_OK)
                    state_next = S_ERR;
                else
                begin
                    iter_next  = ishph_pkg::ITER_W'(1) << stat.expo;
                    first_next = 1'b1;
                    state_next = S_MSG_START;
                end
            end
            S_MSG_START:
            begin
                cmd.msg_init = 1'b1;
                blk_next     = 1'b0;
                state_next   = S_BLK_START;
            end
            S_BLK_START:
            begin
                cmd.blk_init = 1'b1;
                pos_next     = '0;
                state_next   = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load = 1'b1;
                pos_next = pos_reg + 1'b1;
                if (pos_reg == 7'd127)
                    state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                t_next     = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                t_next    = t_reg + 1'b1;
                if (t_reg == 7'd79)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add = 1'b1;
                if (!blk_reg && stat.two_blocks)
                begin
                    blk_next   = 1'b1;
                    state_next = S_BLK_START;
                end
                else
                    state_next = S_MSG_DONE;
            end
            S_MSG_DONE:
            begin
                cmd.copy_hb = 1'b1;
                epos_next   = '0;
                if (first_reg)
                begin
                    first_next = 1'b0;
                    state_next = S_MSG_START;
                end
                else
                begin
                    iter_next = iter_reg - 1'b1;
                    if (iter_reg == ishph_pkg::ITER_W'(1))
                        state_next = S_EMIT;
                    else
                        state_next = S_MSG_START;
                end
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                last      = (epos_reg == 6'(ishph_pkg::HASH_CHARS - 1));
                if (out_acc)
                begin
                    epos_next = epos_reg + 1'b1;
                    if (last)
                    begin
                        cmd.clear_fills = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end
            S_ERR:
            begin
                out_valid    = 1'b1;
                last         = 1'b1;
                status       = stat_reg;
                cmd.emit_err = 1'b1;
                if (out_acc)
                begin
                    cmd.clear_fills = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/iterated_sha512_password_hash_top.sv =====
// ----------------------------------------------------------------------------
// iterated_sha512_password_hash_top: iterated SHA-512 password hash
// Loads a "$S$" setting and a password, runs the iterated hash and returns
// the 55-character hash string.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one request per cycle carries opcode and
// data_byte. Setting and password bytes are taken back to back, one a cycle.
// A finish request stalls the input until its results are all delivered.
// Output channel (out_valid/out_stall): one request per character (out_char,
// status, last). A bad setting gives one result with out_char 0, the error
// status and last set. A good one gives 55 results.
// Hash sequence: each SHA-512 compression runs a block setup, 128 byte loads
// into the schedule window, one pipeline flush, 80 rounds through the single
// round unit and a digest add. Messages of up to 111 bytes use one block,
// longer ones two, plus a message start and a message done step per message;
// a run is 2^exponent + 1 messages. After that one character leaves per cycle
// unless out_stall is high, in which case the current result holds.
// Reset clears fill counts and the sequencer; store contents are not cleared.
// ----------------------------------------------------------------------------
module iterated_sha512_password_hash_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic [2:0] status,
    output logic       last
);

    ishph_pkg::cmd_t  cmd;
    ishph_pkg::stat_t stat;

    // sequencer
    ishph_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .last      (last),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    ishph_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (data_byte),
        .stat      (stat),
        .out_char  (out_char)
    );

endmodule

// ===== dv/ishph_scoreboard.sv =====
// ----------------------------------------------------------------------------
// ishph_scoreboard: predictor and result checker for the password hash block
// Watches both channels, recomputes each finish request with its own SHA-512
// and string encoder, and compares every output request field by field.
// ----------------------------------------------------------------------------
module ishph_scoreboard
    import ishph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [7:0] data_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_char,
    input  logic [2:0] status,
    input  logic       last,
    output int         fail_count,
    output int         chars_waiting
);

    typedef logic [7:0] byte_q_t [$];
    typedef logic [7:0] digest_t [64];

    typedef struct {
        logic [7:0] ch;
        logic [2:0] st;
        logic       lst;
    } hash_char_t;

    localparam logic [63:0] K_TAB [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [63:0] H_INIT [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    string symbols = "./0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

    // loaded state as the block should hold it
    logic [7:0]  setting_bytes [SET_LEN];
    int          setting_count;
    byte_q_t     password_bytes;
    logic        password_dropped;
    hash_char_t  hash_chars_due [$];

    assign chars_waiting = hash_chars_due.size();

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic digest_t sha512_of(input byte_q_t msg);
        logic [63:0] hw [8];
        logic [63:0] v [8];
        logic [63:0] w [80];
        logic [63:0] t1, t2, s0, s1, bitlen;
        byte_q_t     p;
        digest_t     d;
        p = msg;
        bitlen = 64'(msg.size()) * 8;
        p.push_back(8'h80);
        while ((p.size() % 128) != 112)
            p.push_back(8'h00);
        for (int i = 0; i < 8; i++)
            p.push_back(8'h00);
        for (int i = 7; i >= 0; i--)
            p.push_back(bitlen[8*i +: 8]);
        for (int j = 0; j < 8; j++)
            hw[j] = H_INIT[j];
        for (int base = 0; base < p.size(); base += 128)
        begin
            for (int t = 0; t < 80; t++)
            begin
                if (t < 16)
                begin
                    w[t] = '0;
                    for (int j = 0; j < 8; j++)
                        w[t] = {w[t][55:0], p[base + 8*t + j]};
                end
                else
                begin
                    s0 = ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7);
                    s1 = ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6);
                    w[t] = s1 + w[t-7] + s0 + w[t-16];
                end
            end
            for (int j = 0; j < 8; j++)
                v[j] = hw[j];
            for (int t = 0; t < 80; t++)
            begin
                t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + w[t];
                t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int j = 0; j < 8; j++)
                hw[j] += v[j];
        end
        for (int j = 0; j < 64; j++)
            d[j] = hw[j/8][8*(7 - j%8) +: 8];
        return d;
    endfunction

    function automatic int symbol_index(input logic [7:0] c);
        for (int i = 0; i < 64; i++)
            if (symbols[i] == c)
                return i;
        return 64;
    endfunction

    // first failing setting check, in the order the block applies them
    function automatic logic [2:0] setting_verdict(output int expo);
        string pfx;
        pfx = "$S$";
        expo = 0;
        for (int i = 0; i < 3; i++)
            if (setting_count <= i || setting_bytes[i] != pfx[i])
                return ST_BAD_PFX;
        if (setting_count < 4)
            return ST_BAD_EXP;
        expo = symbol_index(setting_bytes[3]);
        if (expo < MIN_EXP || expo > MAX_EXP)
            return ST_BAD_EXP;
        if (setting_count < SET_LEN)
            return ST_SHORT_SET;
        if (password_dropped)
            return ST_PWD_LONG;
        return ST_OK;
    endfunction

    // compute the full hash string for the current setting and password
    task automatic predict_finish();
        logic [2:0] st;
        int         expo;
        byte_q_t    m;
        digest_t    h;
        hash_char_t c;
        int         g, k, b;
        logic [23:0] grp;
        st = setting_verdict(expo);
        if (st != ST_OK)
        begin
            c.ch = 8'h00; c.st = st; c.lst = 1'b1;
            hash_chars_due.push_back(c);
        end
        else
        begin
            m = {};
            for (int i = 4; i < SET_LEN; i++)
                m.push_back(setting_bytes[i]);
            m = {m, password_bytes};
            h = sha512_of(m);
            for (longint n = 0; n < (64'd1 << expo); n++)
            begin
                m = {};
                for (int i = 0; i < 64; i++)
                    m.push_back(h[i]);
                m = {m, password_bytes};
                h = sha512_of(m);
            end
            for (int pos = 0; pos < HASH_CHARS; pos++)
            begin
                c.st = ST_OK;
                c.lst = (pos == HASH_CHARS - 1);
                if (pos < SET_LEN)
                    c.ch = setting_bytes[pos];
                else
                begin
                    g = (pos - SET_LEN) / 4;
                    k = (pos - SET_LEN) % 4;
                    b = g * 3;
                    grp = '0;
                    for (int j = 0; j < 3; j++)
                        if (b + j < 64)
                            grp[8*j +: 8] = h[b + j];
                    c.ch = symbols[(grp >> (6 * k)) & 24'h3f];
                end
                hash_chars_due.push_back(c);
            end
        end
        setting_count = 0;
        password_bytes = {};
        password_dropped = 1'b0;
    endtask

    // result compare first, then the new request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setting_count = 0;
            password_bytes = {};
            password_dropped = 1'b0;
            fail_count = 0;
            hash_chars_due = {};
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (hash_chars_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result char=%h status=%0d last=%b",
                             $time, out_char, status, last);
                end
                else
                begin
                    if (out_char !== hash_chars_due[0].ch || status !== hash_chars_due[0].st
                        || last !== hash_chars_due[0].lst)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected char=%h status=%0d last=%b, got char=%h status=%0d last=%b",
                                 $time, hash_chars_due[0].ch, hash_chars_due[0].st,
                                 hash_chars_due[0].lst, out_char, status, last);
                    end
                    void'(hash_chars_due.pop_front());
                end
            end
            if (in_valid && !in_stall)
            begin
                case (opcode)
                    OP_SETTING:
                        if (setting_count < SET_LEN)
                        begin
                            setting_bytes[setting_count] = data_byte;
                            setting_count++;
                        end
                    OP_PASSWORD:
                        if (password_bytes.size() < MAX_PWD)
                            password_bytes.push_back(data_byte);
                        else
                            password_dropped = 1'b1;
                    OP_FINISH:
                        predict_finish();
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== dv/tb_iterated_sha512_password_hash_top.sv =====
// ----------------------------------------------------------------------------
// tb_iterated_sha512_password_hash_top: stimulus and verdict
// Loads settings and passwords with random gaps and output stalls, covering
// good hashes at low exponents, every error status and ignored requests.
// ----------------------------------------------------------------------------
module tb_iterated_sha512_password_hash_top;
    import ishph_pkg::*;

    localparam int  IDLE_LIMIT = 400000;
    localparam logic [1:0] OP_NONE = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_char;
    logic [2:0] status;
    logic       last;
    int         fail_count;
    int         chars_waiting;

    int  idle_cycles;
    int  requests_sent;
    int  hash_runs;
    int  error_runs;
    bit  send_busy;
    bit  recv_busy;
    bit  char_taken;
    int  stall_left;

    iterated_sha512_password_hash_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .status    (status),
        .last      (last)
    );

    ishph_scoreboard i_scoreboard
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .data_byte     (data_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_char      (out_char),
        .status        (status),
        .last          (last),
        .fail_count    (fail_count),
        .chars_waiting (chars_waiting)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        if (out_valid && !out_stall)
            char_taken = 1'b1;
    end

    // receiver: random stall per output request
    always @(negedge clk)
    begin
        if (char_taken)
        begin
            char_taken = 1'b0;
            stall_left = recv_busy ? $urandom_range(16) : 0;
        end
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
            out_stall <= 1'b0;
    end

    // one request, with a random gap before it
    task automatic send(input logic [1:0] op, input logic [7:0] d);
        int gap;
        bit stalled;
        gap = send_busy ? $urandom_range(16) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        data_byte <= d;
        // stall is stable between the falling and the rising edge
        stalled = in_stall;
        @(posedge clk);
        while (stalled)
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
        requests_sent++;
        if (op == OP_FINISH)
            wait_idle();
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (chars_waiting != 0)
            @(posedge clk);
    endtask

    // random idle profile for the next phase
    task automatic pick_pace();
        send_busy = ($urandom_range(3) != 0);
        recv_busy = ($urandom_range(3) != 0);
    endtask

    // random exponent character that never selects a legal exponent
    function automatic logic [7:0] bad_exp_char();
        logic [7:0] c;
        logic [6:0] ix;
        c  = 8'($urandom_range(255));
        ix = alpha_index(c);
        while (ix >= 7'(MIN_EXP) && ix <= 7'(MAX_EXP))
        begin
            c  = 8'($urandom_range(255));
            ix = alpha_index(c);
        end
        return c;
    endfunction

    task automatic send_setting(input logic [7:0] e_char, input int n);
        logic [7:0] s [4];
        s = '{8'h24, 8'h53, 8'h24, e_char};
        for (int i = 0; i < n; i++)
            send(OP_SETTING, (i < 4) ? s[i] : 8'($urandom_range(255)));
    endtask

    task automatic send_password(input int n);
        for (int i = 0; i < n; i++)
            send(OP_PASSWORD, 8'($urandom_range(255)));
    endtask

    task automatic finish_run(input bit good);
        send(OP_FINISH, 8'($urandom_range(255)));
        if (good)
            hash_runs++;
        else
            error_runs++;
    endtask

    initial
    begin
        int kind;
        int good_left;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_SETTING;
        data_byte = 8'h00;
        out_stall = 1'b0;
        idle_cycles = 0;
        requests_sent = 0;
        hash_runs = 0;
        error_runs = 0;
        send_busy = 1'b0;
        recv_busy = 1'b0;
        char_taken = 1'b0;
        stall_left = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty finish, bad prefix, missing exponent
        finish_run(0);
        send(OP_SETTING, 8'h24);
        send(OP_SETTING, 8'h73);
        finish_run(0);
        send_setting(8'h35, 3);
        finish_run(0);
        // exponent just below range, just above, off alphabet
        send_setting(8'h34, 12);
        finish_run(0);
        send_setting(8'h54, 12);
        finish_run(0);
        send_setting(8'h21, 12);
        finish_run(0);
        // short setting, unused opcode ignored
        send(OP_NONE, 8'hff);
        send_setting(8'h35, 11);
        finish_run(0);
        // lowest exponent, empty password, extra setting bytes ignored
        pick_pace();
        send_setting(8'h35, 14);
        finish_run(1);
        // full password store starting with a zero byte, then one over the limit
        send_setting(8'h35, 12);
        send(OP_PASSWORD, 8'h00);
        send_password(MAX_PWD - 1);
        finish_run(1);
        send_setting(8'h35, 12);
        send_password(MAX_PWD + 1);
        finish_run(0);
        // exponent one step up
        send_setting(8'h36, 12);
        send_password(3);
        finish_run(1);

        // random runs: up to nine well-formed, the rest broken
        good_left = 9;
        while (requests_sent < 380)
        begin
            pick_pace();
            kind = $urandom_range(9);
            if (kind < 5 && good_left > 0)
            begin
                good_left--;
                send_setting(8'h35, 12);
                send_password(($urandom_range(7) == 0) ? $urandom_range(60)
                                                        : $urandom_range(40));
                finish_run(1);
            end
            else
            begin
                if (kind == 5)
                    send_setting(bad_exp_char(), $urandom_range(12));
                else if (kind == 6)
                    send_setting(bad_exp_char(), 12);
                else if (kind == 7)
                    send_setting(8'h35, $urandom_range(4, 11));
                else
                begin
                    send_setting(8'h35, 12);
                    send_password($urandom_range(MAX_PWD + 1, MAX_PWD + 6));
                end
                if ($urandom_range(1))
                    send(OP_NONE, 8'($urandom_range(255)));
                send_password($urandom_range(4));
                finish_run(0);
            end
        end

        wait_idle();
        repeat (50) @(posedge clk);
        $display("Ran %0d requests: %0d full hash runs and %0d rejected settings.",
                 requests_sent, hash_runs, error_runs);
        $display("Errors covered bad prefix, exponent range, short setting and overflow.");
        if (chars_waiting != 0)
            $display("%0t: %0d expected results never arrived", $time, chars_waiting);
        if (fail_count == 0 && chars_waiting == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
